### rtl/sat_pkg.sv
`default_nettype none

package sat_pkg;

  // item geometry
  localparam int CORNERS   = 4;
  localparam int POINTS    = 2 * CORNERS;
  localparam int AXES      = 4;
  localparam int FIELD_W   = 32;
  localparam int IN_FIELDS = 10;

  // field slots in the input request
  localparam int FLD_A_POS = 8;
  localparam int FLD_B_POS = 9;

  // corner order within a rectangle
  localparam int CRN_UL = 0;
  localparam int CRN_LL = 1;
  localparam int CRN_UR = 2;
  localparam int CRN_LR = 3;

  // stream widths
  localparam int IN_DATA_W  = IN_FIELDS * FIELD_W;
  localparam int OUT_DATA_W = 8;

  // per-stage advance strobes from the top-level pipeline control
  typedef struct packed {
    logic geom;
    logic prod;
    logic dot;
    logic span;
    logic res;
  } sat_adv_t;

endpackage

`default_nettype wire

### rtl/sat_geom.sv
`default_nettype none

module sat_geom
  import sat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire sat_adv_t                       adv,
  input  wire logic [IN_DATA_W-1:0]           data,
  output logic signed [COORD_BITS:0]          pt_x_r [POINTS],
  output logic signed [COORD_BITS:0]          pt_y_r [POINTS],
  output logic signed [COORD_BITS:0]          ax_x_r [AXES],
  output logic signed [COORD_BITS:0]          ax_y_r [AXES]
);

  localparam int CW = COORD_BITS + 1;

  logic signed [CW-1:0] loc_x [POINTS];
  logic signed [CW-1:0] loc_y [POINTS];
  logic signed [CW-1:0] pos_x [2];
  logic signed [CW-1:0] pos_y [2];
  logic signed [CW-1:0] pt_x_nxt [POINTS];
  logic signed [CW-1:0] pt_y_nxt [POINTS];
  logic signed [CW-1:0] ax_x_nxt [AXES];
  logic signed [CW-1:0] ax_y_nxt [AXES];

  // x sits above y in each field; bits past 2*COORD_BITS are ignored
  function automatic logic signed [CW-1:0] get_x(input logic [FIELD_W-1:0] f);
    logic [63:0] w;
    w = 64'(f);
    return $signed({w[2*COORD_BITS-1], w[2*COORD_BITS-1:COORD_BITS]});
  endfunction

  function automatic logic signed [CW-1:0] get_y(input logic [FIELD_W-1:0] f);
    logic [63:0] w;
    w = 64'(f);
    return $signed({w[COORD_BITS-1], w[COORD_BITS-1:0]});
  endfunction

  // unpack corners and positions
  always_comb begin
    for (int k = 0; k < POINTS; k++) begin
      loc_x[k] = get_x(data[k*FIELD_W +: FIELD_W]);
      loc_y[k] = get_y(data[k*FIELD_W +: FIELD_W]);
    end
    pos_x[0] = get_x(data[FLD_A_POS*FIELD_W +: FIELD_W]);
    pos_y[0] = get_y(data[FLD_A_POS*FIELD_W +: FIELD_W]);
    pos_x[1] = get_x(data[FLD_B_POS*FIELD_W +: FIELD_W]);
    pos_y[1] = get_y(data[FLD_B_POS*FIELD_W +: FIELD_W]);
  end

  // world corners; fit in COORD_BITS+1 bits
  always_comb begin
    for (int k = 0; k < POINTS; k++) begin
      pt_x_nxt[k] = loc_x[k] + pos_x[k / CORNERS];
      pt_y_nxt[k] = loc_y[k] + pos_y[k / CORNERS];
    end
  end

  // edge axes; the body position cancels, so local corners give them exactly
  always_comb begin
    ax_x_nxt[0] = loc_x[CRN_UR] - loc_x[CRN_UL];
    ax_y_nxt[0] = loc_y[CRN_UR] - loc_y[CRN_UL];
    ax_x_nxt[1] = loc_x[CRN_UR] - loc_x[CRN_LR];
    ax_y_nxt[1] = loc_y[CRN_UR] - loc_y[CRN_LR];
    ax_x_nxt[2] = loc_x[CORNERS + CRN_UL] - loc_x[CORNERS + CRN_LL];
    ax_y_nxt[2] = loc_y[CORNERS + CRN_UL] - loc_y[CORNERS + CRN_LL];
    ax_x_nxt[3] = loc_x[CORNERS + CRN_UL] - loc_x[CORNERS + CRN_UR];
    ax_y_nxt[3] = loc_y[CORNERS + CRN_UL] - loc_y[CORNERS + CRN_UR];
  end

  always_ff @(posedge clk) begin
    if (adv.geom) begin
      pt_x_r <= pt_x_nxt;
      pt_y_r <= pt_y_nxt;
      ax_x_r <= ax_x_nxt;
      ax_y_r <= ax_y_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sat_proj.sv
`default_nettype none

module sat_proj
  import sat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire sat_adv_t                       adv,
  input  wire logic signed [COORD_BITS:0]     pt_x [POINTS],
  input  wire logic signed [COORD_BITS:0]     pt_y [POINTS],
  input  wire logic signed [COORD_BITS:0]     ax_x [AXES],
  input  wire logic signed [COORD_BITS:0]     ax_y [AXES],
  output logic signed [2*COORD_BITS+2:0]      dot_r [AXES*POINTS]
);

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int DW = PW + 1;
  localparam int NP = AXES * POINTS;

  logic signed [PW-1:0] px_r [NP];
  logic signed [PW-1:0] py_r [NP];

  // one product per coordinate, per axis and corner; index = axis*POINTS + corner
  always_ff @(posedge clk) begin
    if (adv.prod) begin
      for (int i = 0; i < NP; i++) begin
        px_r[i] <= PW'(pt_x[i % POINTS]) * PW'(ax_x[i / POINTS]);
        py_r[i] <= PW'(pt_y[i % POINTS]) * PW'(ax_y[i / POINTS]);
      end
    end
  end

  // dot product sums
  always_ff @(posedge clk) begin
    if (adv.dot) begin
      for (int i = 0; i < NP; i++) begin
        dot_r[i] <= DW'(px_r[i]) + DW'(py_r[i]);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sat_range.sv
`default_nettype none

module sat_range
  import sat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire sat_adv_t                       adv,
  input  wire logic signed [2*COORD_BITS+2:0] dot [AXES*POINTS],
  output logic                                colliding_r
);

  localparam int DW = 2 * COORD_BITS + 3;

  logic signed [DW-1:0] a_min_r [AXES];
  logic signed [DW-1:0] a_max_r [AXES];
  logic signed [DW-1:0] b_min_r [AXES];
  logic signed [DW-1:0] b_max_r [AXES];
  logic signed [DW-1:0] a_min_nxt [AXES];
  logic signed [DW-1:0] a_max_nxt [AXES];
  logic signed [DW-1:0] b_min_nxt [AXES];
  logic signed [DW-1:0] b_max_nxt [AXES];
  logic                 separated;

  // interval of each rectangle on each axis
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      a_min_nxt[a] = dot[a*POINTS];
      a_max_nxt[a] = dot[a*POINTS];
      b_min_nxt[a] = dot[a*POINTS + CORNERS];
      b_max_nxt[a] = dot[a*POINTS + CORNERS];
      for (int k = 1; k < CORNERS; k++) begin
        if (dot[a*POINTS + k] < a_min_nxt[a]) a_min_nxt[a] = dot[a*POINTS + k];
        if (dot[a*POINTS + k] > a_max_nxt[a]) a_max_nxt[a] = dot[a*POINTS + k];
        if (dot[a*POINTS + CORNERS + k] < b_min_nxt[a]) begin
          b_min_nxt[a] = dot[a*POINTS + CORNERS + k];
        end
        if (dot[a*POINTS + CORNERS + k] > b_max_nxt[a]) begin
          b_max_nxt[a] = dot[a*POINTS + CORNERS + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.span) begin
      a_min_r <= a_min_nxt;
      a_max_r <= a_max_nxt;
      b_min_r <= b_min_nxt;
      b_max_r <= b_max_nxt;
    end
  end

  // touching intervals overlap; any strict gap separates
  always_comb begin
    separated = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if ((a_max_r[a] < b_min_r[a]) || (b_max_r[a] < a_min_r[a])) separated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.res) begin
      colliding_r <= ~separated;
    end
  end

endmodule

`default_nettype wire

### rtl/sat_rectangle_collision.sv
`default_nettype none

// Separating-axis collision test for two oriented rectangles. Each input
// request carries four local corners and a world position per rectangle,
// packed as signed x over signed y of COORD_BITS bits each; the result is
// one flag, 1 when no edge axis of either rectangle separates them (touching
// counts as a collision). The block keeps no state and takes one request per
// clock while in_tready is high, which needs out_tready or an empty stage. A
// result passes six registers: input register, world corners and axes, 64
// coordinate products, dot sums, per-axis min/max, and the separation compare
// into the output register.
// Every stage carries its own valid bit, so the pipeline keeps filling while
// a result waits for out_tready.

module sat_rectangle_collision
  import sat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // low bit up: a_corner_ul, a_corner_ll, a_corner_ur, a_corner_lr,
  // b_corner_ul, b_corner_ll, b_corner_ur, b_corner_lr, a_position,
  // b_position, 32 bits each
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // low bit up: colliding, then zero fill
  output logic [OUT_DATA_W-1:0]       out_tdata
);

  logic                 in_v_r, geom_v_r, prod_v_r, dot_v_r, span_v_r, out_v_r;
  logic                 in_adv;
  sat_adv_t             adv;
  logic [IN_DATA_W-1:0] data_r;
  logic                 colliding;

  logic signed [COORD_BITS:0]     pt_x [POINTS];
  logic signed [COORD_BITS:0]     pt_y [POINTS];
  logic signed [COORD_BITS:0]     ax_x [AXES];
  logic signed [COORD_BITS:0]     ax_y [AXES];
  logic signed [2*COORD_BITS+2:0] dot  [AXES*POINTS];

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv.res  = ~out_v_r  | out_tready;
    adv.span = ~span_v_r | adv.res;
    adv.dot  = ~dot_v_r  | adv.span;
    adv.prod = ~prod_v_r | adv.dot;
    adv.geom = ~geom_v_r | adv.prod;
    in_adv   = ~in_v_r   | adv.geom;
  end

  assign in_tready  = in_adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(colliding);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      geom_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      dot_v_r  <= 1'b0;
      span_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_adv)   in_v_r   <= in_tvalid;
      if (adv.geom) geom_v_r <= in_v_r;
      if (adv.prod) prod_v_r <= geom_v_r;
      if (adv.dot)  dot_v_r  <= prod_v_r;
      if (adv.span) span_v_r <= dot_v_r;
      if (adv.res)  out_v_r  <= span_v_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_adv) begin
      data_r <= in_tdata;
    end
  end

  sat_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk    (clk),
    .adv    (adv),
    .data   (data_r),
    .pt_x_r (pt_x),
    .pt_y_r (pt_y),
    .ax_x_r (ax_x),
    .ax_y_r (ax_y)
  );

  sat_proj #(
    .COORD_BITS(COORD_BITS)
  ) u_proj (
    .clk   (clk),
    .adv   (adv),
    .pt_x  (pt_x),
    .pt_y  (pt_y),
    .ax_x  (ax_x),
    .ax_y  (ax_y),
    .dot_r (dot)
  );

  sat_range #(
    .COORD_BITS(COORD_BITS)
  ) u_range (
    .clk         (clk),
    .adv         (adv),
    .dot         (dot),
    .colliding_r (colliding)
  );

endmodule

`default_nettype wire
